// File: design/kr_pkg.sv
// Shared types and constants for the keyed record table.
package kr_pkg;

   localparam int KEY_W    = 27;
   localparam int AGE_W    = 7;
   localparam int GRADE_W  = 10;
   localparam int REC_W    = KEY_W + AGE_W + GRADE_W;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int COUNT_W  = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 3'd0,
      ACT_DELETE = 3'd1,
      ACT_LOOKUP = 3'd2,
      ACT_MODIFY = 3'd3,
      ACT_LIST   = 3'd4
   } kr_action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_MISSING = 2'd3
   } kr_status_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [AGE_W-1:0]   age;
      logic [GRADE_W-1:0] grade;
   } kr_record_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_MOVE,
      S_LIST
   } kr_state_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_LAST,
      PTR_DEC,
      PTR_INC,
      PTR_ZERO
   } kr_ptr_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_INSERT,
      WR_MODIFY,
      WR_MOVE
   } kr_wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } kr_cnt_op_type;

   typedef enum logic [1:0] {
      SLOT_ZERO,
      SLOT_COUNT,
      SLOT_PTR,
      SLOT_HIT
   } kr_slot_sel_type;

   typedef struct packed {
      logic            load_req;
      kr_ptr_sel_type  ptr_sel;
      logic            save_hit;
      kr_wr_sel_type   wr_sel;
      kr_cnt_op_type   cnt_op;
      logic            rsp_en;
      kr_status_type   rsp_status;
      kr_slot_sel_type rsp_slot_sel;
      logic            rsp_rec_en;
      logic            rsp_last;
   } kr_cmd_type;

   typedef struct packed {
      kr_action_type action;
      logic          full;
      logic          empty;
      logic          match;
      logic          ptr_zero;
      logic          ptr_last;
   } kr_stat_type;

endpackage

// File: design/kr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kr_ram #(
   parameter int WIDTH = 44,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/kr_ctrl.sv
// Controller state machine for the keyed record table.
module kr_ctrl
   import kr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ACTION_W-1:0] req_action,
   input  kr_stat_type         stat,
   output kr_cmd_type          cmd,
   output logic                busy
);

   kr_state_type state_ff;
   kr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      cmd.load_req     = 1'b0;
      cmd.ptr_sel      = PTR_HOLD;
      cmd.save_hit     = 1'b0;
      cmd.wr_sel       = WR_NONE;
      cmd.cnt_op       = CNT_HOLD;
      cmd.rsp_en       = 1'b0;
      cmd.rsp_status   = ST_OK;
      cmd.rsp_slot_sel = SLOT_ZERO;
      cmd.rsp_rec_en   = 1'b0;
      cmd.rsp_last     = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               case (kr_action_type'(req_action))
                  ACT_INSERT: begin
                     cmd.rsp_en = 1'b1;
                     if (stat.full) begin
                        cmd.rsp_status = ST_FULL;
                     end else begin
                        cmd.wr_sel       = WR_INSERT;
                        cmd.cnt_op       = CNT_INC;
                        cmd.rsp_slot_sel = SLOT_COUNT;
                     end
                  end
                  ACT_DELETE, ACT_LOOKUP: begin
                     if (stat.empty) begin
                        cmd.rsp_en     = 1'b1;
                        cmd.rsp_status = ST_EMPTY;
                     end else begin
                        cmd.ptr_sel = PTR_LAST;
                        state_in    = S_SCAN;
                     end
                  end
                  ACT_MODIFY: begin
                     if (stat.empty) begin
                        cmd.rsp_en     = 1'b1;
                        cmd.rsp_status = ST_MISSING;
                     end else begin
                        cmd.ptr_sel = PTR_LAST;
                        state_in    = S_SCAN;
                     end
                  end
                  ACT_LIST: begin
                     if (stat.empty) begin
                        cmd.rsp_en     = 1'b1;
                        cmd.rsp_status = ST_EMPTY;
                     end else begin
                        cmd.ptr_sel = PTR_ZERO;
                        state_in    = S_LIST;
                     end
                  end
                  default: begin
                     cmd.rsp_en = 1'b1;
                  end
               endcase
            end
         end

         // Top slot downwards, so the first hit is the highest matching slot.
         S_SCAN: begin
            if (stat.match) begin
               state_in = S_IDLE;
               case (stat.action)
                  ACT_DELETE: begin
                     cmd.save_hit = 1'b1;
                     cmd.ptr_sel  = PTR_LAST;
                     state_in     = S_MOVE;
                  end
                  ACT_LOOKUP: begin
                     cmd.rsp_en       = 1'b1;
                     cmd.rsp_slot_sel = SLOT_PTR;
                     cmd.rsp_rec_en   = 1'b1;
                  end
                  ACT_MODIFY: begin
                     cmd.wr_sel       = WR_MODIFY;
                     cmd.rsp_en       = 1'b1;
                     cmd.rsp_slot_sel = SLOT_PTR;
                  end
                  default: begin
                     cmd.rsp_en = 1'b1;
                  end
               endcase
            end else if (stat.ptr_zero) begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = ST_MISSING;
               state_in       = S_IDLE;
            end else begin
               cmd.ptr_sel = PTR_DEC;
            end
         end

         // Last record now on the read port: copy it into the freed slot.
         S_MOVE: begin
            cmd.wr_sel       = WR_MOVE;
            cmd.cnt_op       = CNT_DEC;
            cmd.rsp_en       = 1'b1;
            cmd.rsp_slot_sel = SLOT_HIT;
            state_in         = S_IDLE;
         end

         S_LIST: begin
            cmd.rsp_en       = 1'b1;
            cmd.rsp_slot_sel = SLOT_PTR;
            cmd.rsp_rec_en   = 1'b1;
            cmd.rsp_last     = stat.ptr_last;
            if (stat.ptr_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.ptr_sel = PTR_INC;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: design/kr_datapath.sv
// Datapath: record store, count, scan pointer and result registers.
module kr_datapath
   import kr_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  kr_cmd_type          cmd,
   output kr_stat_type         stat,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [KEY_W-1:0]    req_search_key,
   input  logic [KEY_W-1:0]    req_new_key,
   input  logic [AGE_W-1:0]    req_age_in,
   input  logic [GRADE_W-1:0]  req_grade_in,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [KEY_W-1:0]    rsp_key_out,
   output logic [AGE_W-1:0]    rsp_age_out,
   output logic [GRADE_W-1:0]  rsp_grade_out,
   output logic [COUNT_W-1:0]  rsp_count_out,
   output logic                rsp_last
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [AW-1:0]       ptr_ff;
   logic [AW-1:0]       ptr_in;
   logic [AW-1:0]       hit_ff;
   logic [AW-1:0]       last_idx;
   logic [ACTION_W-1:0] action_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [KEY_W-1:0]    new_key_ff;
   logic [AGE_W-1:0]    age_ff;
   logic [GRADE_W-1:0]  grade_ff;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   kr_record_type       wr_rec;
   kr_record_type       rd_rec;
   logic [REC_W-1:0]    rd_data;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   kr_record_type       rsp_rec_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_last_ff;
   logic [SLOT_W-1:0]   slot_sel;

   assign last_idx = AW'(count_ff - CW'(1));
   assign rd_rec   = kr_record_type'(rd_data);

   always_comb begin
      case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CW'(1);
         CNT_DEC: count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   // The RAM reads the next pointer, so its output always shows slot ptr_ff.
   always_comb begin
      case (cmd.ptr_sel)
         PTR_LAST: ptr_in = last_idx;
         PTR_DEC:  ptr_in = ptr_ff - AW'(1);
         PTR_INC:  ptr_in = ptr_ff + AW'(1);
         PTR_ZERO: ptr_in = '0;
         default:  ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = ptr_ff;
      wr_rec  = rd_rec;
      case (cmd.wr_sel)
         WR_INSERT: begin
            wr_addr = AW'(count_ff);
            wr_rec  = '{key: req_search_key, age: req_age_in, grade: req_grade_in};
         end
         WR_MODIFY: begin
            wr_addr = ptr_ff;
            wr_rec  = '{key: new_key_ff, age: age_ff, grade: grade_ff};
         end
         WR_MOVE: begin
            wr_addr = hit_ff;
            wr_rec  = rd_rec;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   kr_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_addr (ptr_in),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.rsp_en;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.save_hit) begin
         hit_ff <= ptr_ff;
      end
      if (cmd.load_req) begin
         action_ff  <= req_action;
         key_ff     <= req_search_key;
         new_key_ff <= req_new_key;
         age_ff     <= req_age_in;
         grade_ff   <= req_grade_in;
      end
   end

   always_comb begin
      case (cmd.rsp_slot_sel)
         SLOT_COUNT: slot_sel = SLOT_W'(count_ff);
         SLOT_PTR:   slot_sel = SLOT_W'(ptr_ff);
         SLOT_HIT:   slot_sel = SLOT_W'(hit_ff);
         default:    slot_sel = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_en) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_slot_ff   <= slot_sel;
         rsp_rec_ff    <= cmd.rsp_rec_en ? rd_rec : '0;
         rsp_count_ff  <= COUNT_W'(count_in);
         rsp_last_ff   <= cmd.rsp_last;
      end
   end

   assign stat.action   = kr_action_type'(action_ff);
   assign stat.full     = (count_ff == CW'(CAPACITY));
   assign stat.empty    = (count_ff == '0);
   assign stat.match    = (rd_rec.key == key_ff);
   assign stat.ptr_zero = (ptr_ff == '0);
   assign stat.ptr_last = (ptr_ff == last_idx);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_key_out   = rsp_rec_ff.key;
   assign rsp_age_out   = rsp_rec_ff.age;
   assign rsp_grade_out = rsp_rec_ff.grade;
   assign rsp_count_out = rsp_count_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// File: design/keyed_record_table.sv
// Insert, refusals on an empty or full table and unknown actions: result in the cycle after the transfer.
// Lookup, modify and delete scan the store from the top slot down, one slot a cycle through the
// RAM read port; a delete hit then copies the last record into the freed slot as it gives its result.
// List: the pointer is loaded with slot zero, then one record a cycle from slot zero up.
// A new command is taken in the cycle its last result is shown; busy is high until then.
// Synchronous reset empties the table at once; store contents are left as they are.
module keyed_record_table
   import kr_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [KEY_W-1:0]    req_search_key,
   input  logic [KEY_W-1:0]    req_new_key,
   input  logic [AGE_W-1:0]    req_age_in,
   input  logic [GRADE_W-1:0]  req_grade_in,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic [KEY_W-1:0]    rsp_key_out,
   output logic [AGE_W-1:0]    rsp_age_out,
   output logic [GRADE_W-1:0]  rsp_grade_out,
   output logic [COUNT_W-1:0]  rsp_count_out,
   output logic                rsp_last
);

   kr_cmd_type  cmd;
   kr_stat_type stat;

   kr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   kr_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_action),
      .req_search_key (req_search_key),
      .req_new_key    (req_new_key),
      .req_age_in     (req_age_in),
      .req_grade_in   (req_grade_in),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_key_out    (rsp_key_out),
      .rsp_age_out    (rsp_age_out),
      .rsp_grade_out  (rsp_grade_out),
      .rsp_count_out  (rsp_count_out),
      .rsp_last       (rsp_last)
   );

endmodule

// File: design/kr_checker.sv
// Port-level checks for the keyed record table, bound to the top level.
module kr_checker
   import kr_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [SLOT_W-1:0]   rsp_slot,
   input logic [KEY_W-1:0]    rsp_key_out,
   input logic [COUNT_W-1:0]  rsp_count_out,
   input logic                rsp_last
);

   // Every transfer leads either to a result or to a busy period.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("command transfer left no trace");

   // A listing that is not finished keeps the block busy and streams on.
   a_list_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("list unfinished while idle");

   a_list_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap in list results");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_slot == '0 && rsp_key_out == '0))
      else $error("failed result carries slot or record data");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_count_out == COUNT_W'(CAPACITY)))
      else $error("full reported below capacity");

endmodule

bind keyed_record_table kr_checker #(
   .CAPACITY (CAPACITY)
) u_kr_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_status    (rsp_status),
   .rsp_slot      (rsp_slot),
   .rsp_key_out   (rsp_key_out),
   .rsp_count_out (rsp_count_out),
   .rsp_last      (rsp_last)
);
